// ===== hw/rtl/wdiv_pkg.sv =====
// Shared widths, step count and stage payload type for the wide divider.
`timescale 1ns / 1ps
`default_nettype none

package wdiv_pkg;

    localparam int DATA_W  = 64;
    localparam int STEPS   = 64;
    localparam int TOP_BIT = DATA_W - 1;

    // Payload that travels down the step pipeline.
    // Normal path: rem is the partial remainder, low holds dividend bits not yet
    // shifted in, quo collects quotient bits from the right.
    // Overflow path: quo holds the dividend high half, rem the low half, untouched.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] div;
        logic              ovf;
    } t_stage;

    // Status of the output register pair.
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_skid_status;

endpackage : wdiv_pkg

`default_nettype wire

// ===== hw/rtl/wdiv_step.sv =====
// One registered shift-and-subtract step of the restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module wdiv_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire wdiv_pkg::t_stage i_data,
    output logic                 o_valid,
    output wdiv_pkg::t_stage     o_data
);
    import wdiv_pkg::*;

    logic              r_valid;
    t_stage            r_data;
    t_stage            n_data;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W:0]   diff;
    logic              take;

    always_comb begin
        shifted = {i_data.rem[TOP_BIT-1:0], i_data.low[TOP_BIT]};
        diff    = {1'b0, shifted} - {1'b0, i_data.div};
        // A bit shifted out of the top forces the subtraction.
        take    = i_data.rem[TOP_BIT] | ~diff[DATA_W];
        n_data  = i_data;
        if (!i_data.ovf) begin
            n_data.rem = take ? diff[DATA_W-1:0] : shifted;
            n_data.low = {i_data.low[TOP_BIT-1:0], 1'b0};
            n_data.quo = {i_data.quo[TOP_BIT-1:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : wdiv_step

`default_nettype wire

// ===== hw/rtl/wdiv_out_skid.sv =====
// Output register with one skid entry; gives a registered pipeline advance.
`timescale 1ns / 1ps
`default_nettype none

module wdiv_out_skid (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire wdiv_pkg::t_stage       i_data,
    output logic                        o_advance,
    input  wire logic                   i_ready,
    output logic                        o_valid,
    output wdiv_pkg::t_stage            o_data,
    output wdiv_pkg::t_skid_status      o_status
);
    import wdiv_pkg::*;

    logic   r_out_valid;
    logic   r_skid_valid;
    t_stage r_out;
    t_stage r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_advance           = ~r_skid_valid;
    assign o_valid             = r_out_valid;
    assign o_data              = r_out;
    assign o_status.out_valid  = r_out_valid;
    assign o_status.skid_valid = r_skid_valid;

endmodule : wdiv_out_skid

`default_nettype wire

// ===== hw/rtl/wide_divide_128_by_64_core.sv =====
// Top level of the pipelined 128-by-64 unsigned divider.
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined unsigned divide of a 128-bit dividend by a 64-bit divisor.
// A request carries the dividend as high and low halves plus the divisor and
// yields exactly one result. When the divisor is greater than the high half,
// the result is the 64-bit quotient and remainder of a restoring division;
// otherwise (including a zero divisor) overflow is flagged, the quotient
// carries the high half and the remainder the low half. Rate: one request per
// cycle while the output skid entry is empty. A request passes through the
// entry register, which loads at the accepting edge, then 64 step stages each
// holding one 64-bit subtract-and-compare, then one output register. The
// pipeline advances as a whole whenever the output skid entry is empty, so
// o_ready is a registered signal; a stalled result parks in the skid entry
// while the pipeline still takes one more request.
module wide_divide_128_by_64_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [wdiv_pkg::DATA_W-1:0] i_dividend_high,
    input  wire logic [wdiv_pkg::DATA_W-1:0] i_dividend_low,
    input  wire logic [wdiv_pkg::DATA_W-1:0] i_divisor_value,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [wdiv_pkg::DATA_W-1:0]      o_quotient_value,
    output logic [wdiv_pkg::DATA_W-1:0]      o_remainder_value,
    output logic                             o_overflow_flag
);
    import wdiv_pkg::*;

    // Stage 0 is the entry register; stage k holds the state after k steps.
    logic         stage_valid [STEPS+1];
    t_stage       stage_data  [STEPS+1];
    logic         advance;
    t_stage       n_entry;
    t_stage       out_data;
    t_skid_status skid_status;

    // Build the entry payload: decide overflow up front, then either seed the
    // division or park both halves for pass-through.
    always_comb begin
        n_entry.div = i_divisor_value;
        n_entry.ovf = ~(i_divisor_value > i_dividend_high);
        if (n_entry.ovf) begin
            n_entry.quo = i_dividend_high;
            n_entry.rem = i_dividend_low;
            n_entry.low = '0;
        end else begin
            n_entry.quo = '0;
            n_entry.rem = i_dividend_high;
            n_entry.low = i_dividend_low;
        end
    end

    logic   r_entry_valid;
    t_stage r_entry;

    // Advance the entry register with the rest of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= 1'b0;
        end else if (advance) begin
            r_entry_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_entry <= n_entry;
        end
    end

    assign stage_valid[0] = r_entry_valid;
    assign stage_data[0]  = r_entry;

    // One subtract-and-compare per stage, 64 stages.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        wdiv_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (stage_valid[k]),
            .i_data  (stage_data[k]),
            .o_valid (stage_valid[k+1]),
            .o_data  (stage_data[k+1])
        );
    end

    // Hold finished results at the port; drive the pipeline advance.
    wdiv_out_skid u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid[STEPS] & advance),
        .i_data    (stage_data[STEPS]),
        .o_advance (advance),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_data    (out_data),
        .o_status  (skid_status)
    );

    assign o_ready           = advance;
    assign o_quotient_value  = out_data.quo;
    assign o_remainder_value = out_data.rem;
    assign o_overflow_flag   = out_data.ovf;

    // A parked skid entry means the output register is full.
    a_skid_implies_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_status.skid_valid |-> skid_status.out_valid)
        else $error("skid entry valid with empty output register");

    // A completed division leaves a remainder below its divisor.
    a_rem_below_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid[STEPS] && !stage_data[STEPS].ovf) |->
        (stage_data[STEPS].rem < stage_data[STEPS].div))
        else $error("final remainder not below divisor");

    // While the pipeline is frozen the last step's contents do not move.
    a_freeze_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && stage_valid[STEPS]) |=>
        (stage_valid[STEPS] && $stable(stage_data[STEPS])))
        else $error("last step changed while pipeline frozen");

endmodule : wide_divide_128_by_64_core

`default_nettype wire
